>>> hw/rtl/assert_macros.svh
// Assertion macros for the console writer RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define TCCW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/tccw_pkg.sv
// Package for the text console cell writer: geometry constants, codes and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none
package tccw_pkg;

  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int CELL_COUNT = ROWS * COLS;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int LIN_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;

  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [ATTR_W-1:0] TEXT_ATTRIBUTE = 8'h07;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CLEAR = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic take;
    logic step;
    logic sweep_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_clear;
    logic sweep_last;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/text_console_cell_writer.sv
// Top level of the text console cell writer: joins controller and datapath
// to the stream ports. Depends on tccw_pkg, tccw_ctrl, tccw_datapath, assert_macros.svh.
//
// Each input word either clears the screen (tuser set) or puts a character.
// A newline moves the cursor to the next row; other characters are stored
// with attribute 0x07 and advance the cursor. Every input word yields one
// result word: what was written, whether the screen was cleared, and the
// cursor position after the word.
// A plain character or newline gives its result in the cycle after it is
// taken, and if the receiver takes that result, the next word can be taken
// in that same cycle, so such words stream at one per cycle. A clear, or a
// character that arrives past the last cell, runs a sweep over every cell
// through the single write port of the cell store and then a finishing
// step; no word is taken meanwhile. After reset the same sweep zeroes the
// store before the first word is taken. When the receiver stalls, the
// result stays in the output register; one further word can be processed
// only once that register is free or being drained in the same cycle.
`default_nettype none
`include "assert_macros.svh"
module text_console_cell_writer import tccw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] char_code
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,  // [0] action
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [10:0] cell_index, [18:11] cell_char, [26:19] cell_attribute,
  // [37:27] cursor_after, [39:38] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser   // [0] wrote_cell, [1] screen_cleared
);

  cmd_t              cmd;
  status_t           status;
  logic              wrote_cell, screen_cleared;
  logic [IDX_W-1:0]  cell_index, cursor_after;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attribute;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  tccw_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (s_axis_tuser[0]),
    .char_code_i      (s_axis_tdata[CHAR_W-1:0]),
    .cmd_i            (cmd),
    .status_o         (status),
    .wrote_cell_o     (wrote_cell),
    .cell_index_o     (cell_index),
    .cell_char_o      (cell_char),
    .cell_attribute_o (cell_attribute),
    .screen_cleared_o (screen_cleared),
    .cursor_after_o   (cursor_after)
  );

  assign m_axis_tdata = {2'b00, cursor_after, cell_attribute, cell_char, cell_index};
  assign m_axis_tuser = {screen_cleared, wrote_cell};

  `TCCW_ASSERT(a_cursor_range, m_axis_tvalid |-> (cursor_after <= IDX_W'(CELL_COUNT)), "cursor beyond end position")
  `TCCW_ASSERT(a_attr_consistent, m_axis_tvalid |-> (wrote_cell ? (cell_attribute == TEXT_ATTRIBUTE) : (cell_attribute == '0)), "attribute does not match write flag")
  `TCCW_ASSERT(a_plain_word_result, (s_axis_tvalid && s_axis_tready && !status.need_clear) |=> (m_axis_tvalid && !screen_cleared), "plain word gave no result in the next cycle")
  `TCCW_NEVER(a_sweep_vs_load, cmd.sweep_en && (cmd.step || cmd.finish), "sweep overlaps a cell write")

endmodule
`default_nettype wire

>>> hw/rtl/tccw_datapath.sv
// Datapath of the console writer: cursor registers, cell store, sweep counter
// and the result register. Depends on tccw_pkg.
`default_nettype none
module tccw_datapath import tccw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              action_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic                   wrote_cell_o,
  output logic [IDX_W-1:0]       cell_index_o,
  output logic [CHAR_W-1:0]      cell_char_o,
  output logic [ATTR_W-1:0]      cell_attribute_o,
  output logic                   screen_cleared_o,
  output logic [IDX_W-1:0]       cursor_after_o
);

  logic [ROW_W-1:0]  row_q, row_d, row_b;
  logic [COL_W-1:0]  col_q, col_d, col_b;
  logic [LIN_W-1:0]  lin_q, lin_d, lin_b;
  logic [ADDR_W-1:0] swp_q;
  logic              act_q;
  logic [CHAR_W-1:0] ch_q, ch_sel;
  logic              past_end, is_nl, write_char, sweep_last;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] cells [CELL_COUNT];
  logic              wrote_cell_q, screen_cleared_q;
  logic [IDX_W-1:0]  cell_index_q, cursor_after_q;
  logic [CHAR_W-1:0] cell_char_q;
  logic [ATTR_W-1:0] cell_attribute_q;

  assign past_end   = (row_q == ROW_W'(ROWS));
  assign sweep_last = (swp_q == ADDR_W'(CELL_COUNT - 1));
  assign status_o.need_clear = action_i | ((char_code_i != NEWLINE_CODE) & past_end);
  assign status_o.sweep_last = sweep_last;

  assign ch_sel = cmd_i.finish ? ch_q : char_code_i;
  assign is_nl  = (ch_sel == NEWLINE_CODE);
  assign row_b  = cmd_i.finish ? '0 : row_q;
  assign col_b  = cmd_i.finish ? '0 : col_q;
  assign lin_b  = cmd_i.finish ? '0 : lin_q;

  always_comb begin
    row_d      = row_b;
    col_d      = col_b;
    lin_d      = lin_b;
    write_char = 1'b0;
    if (cmd_i.finish && act_q) begin
      row_d = '0;
      col_d = '0;
      lin_d = '0;
    end else if (!cmd_i.finish && is_nl) begin
      col_d = '0;
      if (past_end) begin
        row_d = ROW_W'(ROWS);
        lin_d = LIN_W'(CELL_COUNT);
      end else begin
        row_d = row_q + ROW_W'(1);
        lin_d = lin_q - LIN_W'(col_q) + LIN_W'(COLS);
      end
    end else begin
      write_char = cmd_i.step | cmd_i.finish;
      lin_d      = lin_b + LIN_W'(1);
      if (col_b == COL_W'(COLS - 1)) begin
        col_d = '0;
        row_d = row_b + ROW_W'(1);
      end else begin
        col_d = col_b + COL_W'(1);
      end
    end
  end

  assign mem_we    = cmd_i.sweep_en | write_char;
  assign mem_addr  = cmd_i.sweep_en ? swp_q : ADDR_W'(lin_b);
  assign mem_wdata = cmd_i.sweep_en ? '0 : {TEXT_ATTRIBUTE, ch_sel};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      lin_q <= '0;
      swp_q <= '0;
    end else begin
      if (cmd_i.step || cmd_i.finish) begin
        row_q <= row_d;
        col_q <= col_d;
        lin_q <= lin_d;
      end
      if (cmd_i.sweep_en) begin
        swp_q <= sweep_last ? '0 : swp_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q <= action_i;
      ch_q  <= char_code_i;
    end
    if (cmd_i.step || cmd_i.finish) begin
      wrote_cell_q     <= write_char;
      cell_index_q     <= write_char ? IDX_W'(lin_b) : '0;
      cell_char_q      <= write_char ? ch_sel : '0;
      cell_attribute_q <= write_char ? TEXT_ATTRIBUTE : '0;
      screen_cleared_q <= cmd_i.finish;
      cursor_after_q   <= IDX_W'(lin_d);
    end
  end

  assign wrote_cell_o     = wrote_cell_q;
  assign cell_index_o     = cell_index_q;
  assign cell_char_o      = cell_char_q;
  assign cell_attribute_o = cell_attribute_q;
  assign screen_cleared_o = screen_cleared_q;
  assign cursor_after_o   = cursor_after_q;

endmodule
`default_nettype wire

>>> hw/rtl/tccw_ctrl.sv
// Controller of the console writer: sequences the clearing sweep, the
// per-word processing and the result handshake. Depends on tccw_pkg.
`default_nettype none
module tccw_ctrl import tccw_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept, load;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (status_i.need_clear) begin
            cmd_o.take = 1'b1;
            state_d    = ST_CLEAR;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign load = cmd_o.step | cmd_o.finish;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire
